FILE: src/vtpd_pkg.sv
// Package for the vertex transform with perspective divide.
// Holds widths, register codes, reset values and the payload structs.
// No dependencies; every other file uses it through scoped names.
package vtpd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int LANE_W     = 16;
	localparam int NUM_LANES  = 4;
	localparam int NUM_DIV    = 3;

	localparam int PROD_W = COORD_BITS + LANE_W;
	localparam int OFFS_W = LANE_W + FRAC_BITS;
	localparam int ACC_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;
	localparam int DIV_W  = ACC_W + COORD_BITS + FRAC_BITS;

	// mac product, mac sum, magnitude, setup, one per quotient bit, saturate
	localparam int NUM_STG = COORD_BITS + 5;

	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X      = 8'd0,
		REG_ROW_Y      = 8'd1,
		REG_ROW_Z      = 8'd2,
		REG_ROW_OFFSET = 8'd3
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] RST_ROW_X      = 64'h0000_0000_0000_0100;
	localparam logic [CFG_W-1:0] RST_ROW_Y      = 64'h0000_0000_0100_0000;
	localparam logic [CFG_W-1:0] RST_ROW_Z      = 64'h0000_0100_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW_OFFSET = 64'h0100_0000_0000_0000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [LANE_W-1:0]     coef_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
	} in_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   w_was_zero;
		logic   clipped;
	} out_t;

	typedef struct packed {
		coord_t quo;
		logic   clip;
		logic   zero;
	} div_res_t;

endpackage

FILE: src/vtpd_mac.sv
// One lane of the matrix product: three multiplies, then sum with offset.
// Two pipeline stages. Uses vtpd_pkg.
module vtpd_mac (
	input  logic            clk,
	input  logic            en,
	input  vtpd_pkg::coord_t px,
	input  vtpd_pkg::coord_t py,
	input  vtpd_pkg::coord_t pz,
	input  vtpd_pkg::coef_t  cx,
	input  vtpd_pkg::coef_t  cy,
	input  vtpd_pkg::coef_t  cz,
	input  vtpd_pkg::coef_t  off,
	output vtpd_pkg::acc_t   acc
);
	logic signed [vtpd_pkg::PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	vtpd_pkg::coef_t off_s1;
	vtpd_pkg::acc_t  acc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= vtpd_pkg::PROD_W'(px) * vtpd_pkg::PROD_W'(cx);
			prod_y_s1 <= vtpd_pkg::PROD_W'(py) * vtpd_pkg::PROD_W'(cy);
			prod_z_s1 <= vtpd_pkg::PROD_W'(pz) * vtpd_pkg::PROD_W'(cz);
			off_s1    <= off;
			acc_s2    <= vtpd_pkg::ACC_W'(prod_x_s1) + vtpd_pkg::ACC_W'(prod_y_s1)
				+ vtpd_pkg::ACC_W'(prod_z_s1)
				+ (vtpd_pkg::ACC_W'(off_s1) <<< vtpd_pkg::FRAC_BITS);
		end
	end

	assign acc = acc_s2;
endmodule

FILE: src/vtpd_div.sv
// One divider lane: (num << FRAC_BITS) / den, truncated toward zero, saturated.
// Restoring division, one quotient bit per stage. Uses vtpd_pkg.
module vtpd_div (
	input  logic                clk,
	input  logic                en,
	input  vtpd_pkg::acc_t      num,
	input  vtpd_pkg::acc_t      den,
	output vtpd_pkg::div_res_t  res
);
	localparam int CB = vtpd_pkg::COORD_BITS;

	logic                        neg_s3, zero_s3;
	logic [vtpd_pkg::ACC_W-1:0]  a_s3, b_s3;

	// index 0 is the setup stage, index j is after j quotient bits
	logic [vtpd_pkg::DIV_W-1:0]  rem_s4  [CB+1];
	logic [vtpd_pkg::ACC_W-1:0]  dvs_s4  [CB+1];
	logic [CB-1:0]               quo_s4  [CB+1];
	logic                        neg_s4  [CB+1];
	logic                        over_s4 [CB+1];
	logic                        zero_s4 [CB+1];

	vtpd_pkg::div_res_t res_sf;

	logic [vtpd_pkg::DIV_W-1:0] dividend, dvs_top;
	logic [CB-1:0]              lim, mag, q_last;
	logic                       clip;

	assign dividend = vtpd_pkg::DIV_W'(a_s3) << vtpd_pkg::FRAC_BITS;
	assign dvs_top  = vtpd_pkg::DIV_W'(b_s3) << CB;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= num[vtpd_pkg::ACC_W-1] ^ den[vtpd_pkg::ACC_W-1];
			a_s3    <= num[vtpd_pkg::ACC_W-1] ? vtpd_pkg::ACC_W'(-num) : vtpd_pkg::ACC_W'(num);
			b_s3    <= den[vtpd_pkg::ACC_W-1] ? vtpd_pkg::ACC_W'(-den) : vtpd_pkg::ACC_W'(den);
			zero_s3 <= (den == '0);

			rem_s4[0]  <= dividend;
			dvs_s4[0]  <= b_s3;
			quo_s4[0]  <= '0;
			neg_s4[0]  <= neg_s3;
			over_s4[0] <= (dividend >= dvs_top);
			zero_s4[0] <= zero_s3;
		end
	end

	for (genvar j = 0; j < CB; j++) begin : g_bit
		localparam int BIT = CB - 1 - j;
		logic [vtpd_pkg::DIV_W-1:0] sub;
		logic                       ge;
		assign sub = vtpd_pkg::DIV_W'(dvs_s4[j]) << BIT;
		assign ge  = (rem_s4[j] >= sub);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s4[j+1]  <= ge ? rem_s4[j] - sub : rem_s4[j];
				dvs_s4[j+1]  <= dvs_s4[j];
				quo_s4[j+1]  <= quo_s4[j] | (CB'(ge) << BIT);
				neg_s4[j+1]  <= neg_s4[j];
				over_s4[j+1] <= over_s4[j];
				zero_s4[j+1] <= zero_s4[j];
			end
		end
	end

	always_comb begin
		q_last = quo_s4[CB];
		lim    = neg_s4[CB] ? CB'(vtpd_pkg::COORD_MIN) : CB'(vtpd_pkg::COORD_MAX);
		clip   = over_s4[CB] || (q_last > lim);
		mag    = clip ? lim : q_last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf.quo  <= neg_s4[CB] ? vtpd_pkg::coord_t'(-mag) : vtpd_pkg::coord_t'(mag);
			res_sf.clip <= clip;
			res_sf.zero <= zero_s4[CB];
		end
	end

	assign res = res_sf;
endmodule

FILE: src/vertex_transform_perspective_divide.sv
// Top level: vertex transform by a 4x4 Q8.8 matrix and perspective divide.
// Instantiates four vtpd_mac lanes and three vtpd_div lanes; uses vtpd_pkg.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     in_data   (vtpd_pkg::in_t)
//   out       out_valid / out_ready   out_data  (vtpd_pkg::out_t)
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per clock while the skid slot is empty. The divider lanes
// retire the quotient one bit per stage.
// arst_n loads the identity matrix and empties the pipeline and output stage.
// A stalled output fills a one-entry skid slot; in_ready drops only while it
// is full, and the whole pipeline holds with it.
module vertex_transform_perspective_divide (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vtpd_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vtpd_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vtpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vtpd_pkg::CFG_W-1:0]      cfg_data
);
	localparam int NS = vtpd_pkg::NUM_STG;
	localparam int LW = vtpd_pkg::LANE_W;

	// matrix rows
	logic [vtpd_pkg::CFG_W-1:0] row_x_q, row_y_q, row_z_q, row_off_q;

	logic [NS-1:0] vld_q;
	logic          en;

	vtpd_pkg::acc_t     acc   [vtpd_pkg::NUM_LANES];
	vtpd_pkg::div_res_t dres  [vtpd_pkg::NUM_DIV];
	vtpd_pkg::out_t     merged;

	vtpd_pkg::out_t out_q, skid_q;
	logic           out_v_q, skid_v_q;

	// Registers take writes at any time; the user writes only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q   <= vtpd_pkg::RST_ROW_X;
			row_y_q   <= vtpd_pkg::RST_ROW_Y;
			row_z_q   <= vtpd_pkg::RST_ROW_Z;
			row_off_q <= vtpd_pkg::RST_ROW_OFFSET;
		end else if (cfg_valid) begin
			// drop writes to unknown indexes
			if (cfg_index == vtpd_pkg::REG_ROW_X)      row_x_q   <= cfg_data;
			if (cfg_index == vtpd_pkg::REG_ROW_Y)      row_y_q   <= cfg_data;
			if (cfg_index == vtpd_pkg::REG_ROW_Z)      row_z_q   <= cfg_data;
			if (cfg_index == vtpd_pkg::REG_ROW_OFFSET) row_off_q <= cfg_data;
		end
	end

	// Advance the pipeline whenever the skid slot is empty.
	assign en       = !skid_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// Lanes 0..2 form x', y', z'; lane 3 forms w.
	for (genvar k = 0; k < vtpd_pkg::NUM_LANES; k++) begin : g_mac
		vtpd_mac u_mac (
			.clk (clk),
			.en  (en),
			.px  (in_data.in_x),
			.py  (in_data.in_y),
			.pz  (in_data.in_z),
			.cx  (vtpd_pkg::coef_t'(row_x_q[k*LW +: LW])),
			.cy  (vtpd_pkg::coef_t'(row_y_q[k*LW +: LW])),
			.cz  (vtpd_pkg::coef_t'(row_z_q[k*LW +: LW])),
			.off (vtpd_pkg::coef_t'(row_off_q[k*LW +: LW])),
			.acc (acc[k])
		);
	end

	for (genvar k = 0; k < vtpd_pkg::NUM_DIV; k++) begin : g_div
		vtpd_div u_div (
			.clk (clk),
			.en  (en),
			.num (acc[k]),
			.den (acc[vtpd_pkg::NUM_LANES-1]),
			.res (dres[k])
		);
	end

	// Merge the divider lanes: a zero w overrides everything, else OR the clips.
	always_comb begin
		if (dres[0].zero) begin
			merged.out_x      = '0;
			merged.out_y      = '0;
			merged.out_z      = '0;
			merged.w_was_zero = 1'b1;
			merged.clipped    = 1'b0;
		end else begin
			merged.out_x      = dres[0].quo;
			merged.out_y      = dres[1].quo;
			merged.out_z      = dres[2].quo;
			merged.w_was_zero = 1'b0;
			merged.clipped    = dres[0].clip | dres[1].clip | dres[2].clip;
		end
	end

	// Output register with one skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en && vld_q[NS-1]) begin
			if (!out_v_q || out_ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_v_q && out_ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[NS-1]) begin
			if (!out_v_q || out_ready) begin
				out_q <= merged;
			end else begin
				skid_q <= merged;
			end
		end else if (out_v_q && out_ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;
endmodule

FILE: src/vtpd_checker.sv
// Port-level checks for the vertex transform block, bound to the top level.
// Uses vtpd_pkg for coordinate limits.
module vtpd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input vtpd_pkg::out_t                  out_data
);
	// a stalled result holds its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// the input stalls only behind a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result waiting");

	// zero w gives zero coordinates and no clip
	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.w_was_zero |->
		out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0
		&& !out_data.clipped)
		else $error("zero w result not cleared");

	// a clip shows at least one coordinate at a range limit
	a_clip_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped |->
		out_data.out_x == vtpd_pkg::COORD_MAX || out_data.out_x == vtpd_pkg::COORD_MIN ||
		out_data.out_y == vtpd_pkg::COORD_MAX || out_data.out_y == vtpd_pkg::COORD_MIN ||
		out_data.out_z == vtpd_pkg::COORD_MAX || out_data.out_z == vtpd_pkg::COORD_MIN)
		else $error("clip flagged without saturated coordinate");
endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for vertex_transform_perspective_divide.
// Depends on vtpd_pkg and the block's RTL; predicts each projected point internally.
// Streams directed and random points under several matrices with random idling.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// index outside the register map, a write to it must change nothing
	localparam logic [vtpd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES   = 3 * (vtpd_pkg::COORD_BITS + 6);
	localparam int MAX_REPORTS    = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	vtpd_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	vtpd_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vtpd_pkg::CFG_W-1:0] cfg_data = '0;

	// predictor copy of the four matrix rows
	logic [vtpd_pkg::CFG_W-1:0] matrix_rows [vtpd_pkg::NUM_LANES];

	vtpd_pkg::in_t  point_q [$];   // points waiting to be offered
	vtpd_pkg::out_t proj_q  [$];   // projections still owed by the block

	bit quiet = 1'b0;    // suppress random idling on both sides
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	int n_results = 0, n_mismatch = 0, n_zero = 0, n_clip = 0, n_points = 0;
	int cycle_cnt = 0;

	always #4 clk = ~clk;

	vertex_transform_perspective_divide dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint coef(logic [vtpd_pkg::CFG_W-1:0] row, int k);
		vtpd_pkg::coef_t c;
		c = row[vtpd_pkg::LANE_W*k +: vtpd_pkg::LANE_W];
		return longint'(c);
	endfunction

	// (num << FRAC_BITS) / den, truncated toward zero, saturated to coord_t
	function automatic vtpd_pkg::coord_t div_sat(longint num, longint den, inout bit clip);
		bit neg;
		longint unsigned a, b, q, r, lim;
		bit over;
		neg = (num < 0) != (den < 0);
		a = (num < 0) ? -num : num;
		b = (den < 0) ? -den : den;
		lim = neg ? (64'd1 << (vtpd_pkg::COORD_BITS - 1))
			: (64'd1 << (vtpd_pkg::COORD_BITS - 1)) - 1;
		q = a / b;
		r = a % b;
		over = q > lim;
		for (int i = 0; i < vtpd_pkg::FRAC_BITS && !over; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= b) begin
				r = r - b;
				q = q + 1;
			end
			if (q > lim)
				over = 1'b1;
		end
		if (over) begin
			clip = 1'b1;
			q = lim;
		end
		return vtpd_pkg::coord_t'(neg ? -q : q);
	endfunction

	function automatic vtpd_pkg::out_t project_point(vtpd_pkg::in_t p);
		longint acc [vtpd_pkg::NUM_LANES];
		vtpd_pkg::out_t o;
		bit clip;
		clip = 1'b0;
		o = '0;
		for (int k = 0; k < vtpd_pkg::NUM_LANES; k++)
			acc[k] = longint'(p.in_x) * coef(matrix_rows[vtpd_pkg::REG_ROW_X], k)
			       + longint'(p.in_y) * coef(matrix_rows[vtpd_pkg::REG_ROW_Y], k)
			       + longint'(p.in_z) * coef(matrix_rows[vtpd_pkg::REG_ROW_Z], k)
			       + coef(matrix_rows[vtpd_pkg::REG_ROW_OFFSET], k)
			         * (longint'(1) << vtpd_pkg::FRAC_BITS);
		if (acc[3] == 0) begin
			o.w_was_zero = 1'b1;
			return o;
		end
		o.out_x = div_sat(acc[0], acc[3], clip);
		o.out_y = div_sat(acc[1], acc[3], clip);
		o.out_z = div_sat(acc[2], acc[3], clip);
		o.clipped = clip;
		return o;
	endfunction

	// Driver: hold the request until accepted, predict it on acceptance.
	always @(posedge clk) begin
		bit next_valid;
		if (arst_n && !(in_valid && !in_ready)) begin
			if (in_valid) begin
				proj_q.push_back(project_point(in_data));
				n_points++;
			end
			next_valid = 1'b0;
			if (point_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
				in_data <= point_q.pop_front();
				next_valid = 1'b1;
			end
			in_valid <= next_valid;
		end
	end

	// One long back-pressure stretch, while the driver keeps offering.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_results >= 140) begin
				hold_done <= 1'b1;
				hold_cycles <= 300;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
			end
		end
	end

	// Monitor: compare each accepted result against the oldest prediction.
	always @(posedge clk) begin
		vtpd_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (proj_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS)
						$display("unexpected result %h", out_data);
				end else begin
					want = proj_q.pop_front();
					n_zero += want.w_was_zero;
					n_clip += want.clipped;
					if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
					    out_data.out_z !== want.out_z ||
					    out_data.w_was_zero !== want.w_was_zero ||
					    out_data.clipped !== want.clipped) begin
						n_mismatch++;
						if (n_mismatch <= MAX_REPORTS)
							$display("mismatch #%0d: expected %h %h %h %b %b, got %h %h %h %b %b",
								n_results, want.out_x, want.out_y, want.out_z,
								want.w_was_zero, want.clipped, out_data.out_x,
								out_data.out_y, out_data.out_z, out_data.w_was_zero,
								out_data.clipped);
					end
				end
			end
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_reg(logic [vtpd_pkg::CFG_IDX_W-1:0] idx,
		logic [vtpd_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		// the write landed at this edge; mirror it
		if (idx <= vtpd_pkg::REG_ROW_OFFSET)
			matrix_rows[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	// Pause the sender until every prediction is retired, plus pipeline depth.
	task automatic drain();
		while (point_q.size() > 0 || in_valid || proj_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_matrix(logic [vtpd_pkg::CFG_W-1:0] rx, ry, rz, ro);
		drain();
		write_reg(vtpd_pkg::REG_ROW_X, rx);
		write_reg(vtpd_pkg::REG_ROW_Y, ry);
		write_reg(vtpd_pkg::REG_ROW_Z, rz);
		write_reg(vtpd_pkg::REG_ROW_OFFSET, ro);
	endtask

	function automatic vtpd_pkg::coord_t rand_coord();
		case ($urandom_range(7))
			0: return vtpd_pkg::COORD_MAX;
			1: return vtpd_pkg::COORD_MIN;
			2: return vtpd_pkg::coord_t'($urandom_range(7)) - vtpd_pkg::coord_t'(4);
			3: return vtpd_pkg::coord_t'($urandom_range(1023)) - vtpd_pkg::coord_t'(512);
			default: return vtpd_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [vtpd_pkg::CFG_W-1:0] rand_row();
		logic [vtpd_pkg::CFG_W-1:0] r;
		for (int k = 0; k < vtpd_pkg::NUM_LANES; k++)
			r[vtpd_pkg::LANE_W*k +: vtpd_pkg::LANE_W] = ($urandom_range(3) == 0)
				? 16'(rand_coord()) : 16'($urandom_range(1023)) - 16'd512;
		return r;
	endfunction

	function automatic vtpd_pkg::in_t mk(vtpd_pkg::coord_t x, vtpd_pkg::coord_t y,
		vtpd_pkg::coord_t z);
		vtpd_pkg::in_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		return p;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			point_q.push_back(mk(rand_coord(), rand_coord(), rand_coord()));
	endtask

	initial begin
		matrix_rows[vtpd_pkg::REG_ROW_X] = vtpd_pkg::RST_ROW_X;
		matrix_rows[vtpd_pkg::REG_ROW_Y] = vtpd_pkg::RST_ROW_Y;
		matrix_rows[vtpd_pkg::REG_ROW_Z] = vtpd_pkg::RST_ROW_Z;
		matrix_rows[vtpd_pkg::REG_ROW_OFFSET] = vtpd_pkg::RST_ROW_OFFSET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity after reset: field extremes pass straight through
		point_q.push_back(mk(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, '0));
		point_q.push_back(mk(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, 16'hffff));
		point_q.push_back(mk(16'h0001, 16'hffff, 16'h5555));
		point_q.push_back(mk(16'haaaa, 16'h5555, 16'haaaa));
		add_random(120);

		// perspective: w = z, so z = 0 gives zero w and small z saturates
		load_matrix(vtpd_pkg::RST_ROW_X, vtpd_pkg::RST_ROW_Y, 64'h0100_0100_0000_0000, '0);
		write_reg(REG_UNMAPPED, 64'hffff_ffff_ffff_ffff);
		point_q.push_back(mk(16'h0100, 16'h0200, '0));
		point_q.push_back(mk(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, 16'h0001));
		point_q.push_back(mk(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, 16'hffff));
		point_q.push_back(mk(16'h0300, -16'h0500, 16'h0200));
		point_q.push_back(mk(-16'h0300, 16'h0500, -16'h0200));
		point_q.push_back(mk(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN));
		add_random(140);

		// largest positive coefficients everywhere, no idling on either side
		load_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
		quiet = 1'b1;
		point_q.push_back(mk(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX));
		point_q.push_back(mk(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN));
		point_q.push_back(mk(16'hffff, '0, '0));
		add_random(90);

		// most negative coefficients everywhere
		load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
		quiet = 1'b0;
		point_q.push_back(mk(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN));
		point_q.push_back(mk(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, '0));
		add_random(90);

		// four random matrices, then an all-zero matrix so that every w is zero
		for (int m = 0; m < 4; m++) begin
			load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
			add_random(50);
		end
		load_matrix('0, '0, '0, '0);
		add_random(10);

		drain();
		$display("%0d points checked over 9 matrices, one long output stall",
			n_points);
		$display("%0d with zero w, %0d saturated, %0d mismatches",
			n_zero, n_clip, n_mismatch);
		if (n_mismatch == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
src/vtpd_pkg.sv
src/vtpd_mac.sv
src/vtpd_div.sv
src/vertex_transform_perspective_divide.sv
src/vtpd_checker.sv
tb/testbench.sv
